// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the RTL files.
// Each macro checks on the rising edge of clk_i and is disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");
// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_SAME(lbl, ante, cons)
`define ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== hdl/rgbhsv_pkg.sv =====
`timescale 1ns / 1ps
package rgbhsv_pkg;

  // Field widths.
  localparam int unsigned ChanW    = 8;
  localparam int unsigned HueW     = 15;
  localparam int unsigned SectorW  = 3;

  // The hue divider produces 12 quotient bits and the saturation divider 8.
  localparam int unsigned HueQW    = 12;
  localparam int unsigned HueRemW  = 20;
  localparam int unsigned SatQW    = 8;
  localparam int unsigned SatRemW  = 16;
  localparam int unsigned DivSteps = HueQW;
  localparam int unsigned SatStart = DivSteps - SatQW;

  // 60 degrees in units of 1/64 degree.
  localparam logic [HueW-1:0] HueSector = 15'd3840;

  // Sector codes, by the channel that holds the maximum.
  localparam logic [SectorW-1:0] SecRed     = 3'd0;
  localparam logic [SectorW-1:0] SecGreen   = 3'd2;
  localparam logic [SectorW-1:0] SecBlue    = 3'd4;
  localparam logic [SectorW-1:0] SecRedWrap = 3'd6;

  // One stage of the shared divider pipeline.
  typedef struct packed {
    logic [HueRemW-1:0] hrem;
    logic [ChanW-1:0]   hdiv;
    logic [HueQW-1:0]   hq;
    logic [SatRemW-1:0] srem;
    logic [ChanW-1:0]   sdiv;
    logic [SatQW-1:0]   sq;
    logic [SectorW-1:0] sector;
    logic               neg;
    logic               gray;
    logic               black;
    logic [ChanW-1:0]   value;
  } div_stage_t;

endpackage

// ===== hdl/rgbhsv_if.sv =====
`timescale 1ns / 1ps
// RGB pixel channel.
interface rgbhsv_rgb_if;
  import rgbhsv_pkg::*;
  logic             valid;
  logic             ready;
  logic [ChanW-1:0] red;
  logic [ChanW-1:0] green;
  logic [ChanW-1:0] blue;
  modport source (output valid, output red, output green, output blue, input ready);
  modport sink (input valid, input red, input green, input blue, output ready);
endinterface

// HSV pixel channel.
interface rgbhsv_hsv_if;
  import rgbhsv_pkg::*;
  logic             valid;
  logic             ready;
  logic [HueW-1:0]  hue;
  logic [ChanW-1:0] saturation;
  logic [ChanW-1:0] value;
  modport source (output valid, output hue, output saturation, output value, input ready);
  modport sink (input valid, input hue, input saturation, input value, output ready);
endinterface

// ===== hdl/rgb_to_hsv_converter.sv =====
`timescale 1ns / 1ps
// Channel   Direction  Fields
// pix_in    in         red[7:0], green[7:0], blue[7:0]
// pix_out   out        hue[14:0], saturation[7:0], value[7:0]
//
// One pixel is accepted per cycle while the output is not stalled. The hue divider resolves
// one quotient bit per stage over 12 stages; the saturation divider runs in the last 8 of
// those stages.
// Reset clears all valid bits; the data registers are not reset.
// When the output register holds a result that is not taken, every stage holds.
`include "assert_macros.svh"

module rgb_to_hsv_converter (
  input logic          clk_i,
  input logic          rst_ni,
  rgbhsv_rgb_if.sink   pix_in,
  rgbhsv_hsv_if.source pix_out
);
  import rgbhsv_pkg::*;

  logic advance;

  // Stage 1: maximum, minimum and hue numerator operands.
  logic [ChanW-1:0]   s1_mx_d, s1_mn_d, s1_p_d, s1_q_d;
  logic [SectorW-1:0] s1_sector_d;
  logic [ChanW-1:0]   s1_mx_q, s1_mn_q, s1_p_q, s1_q_q;
  logic [SectorW-1:0] s1_sector_q;
  logic               s1_valid_q;
  logic               blue_max, green_max;

  // Stage 2 and the divider stages.
  div_stage_t             st_q [DivSteps+1];
  div_stage_t             st_d [DivSteps+1];
  logic [DivSteps:0]      st_valid_q;
  logic [ChanW-1:0]       delta;
  logic [ChanW-1:0]       nabs;
  logic                   neg;

  // Output register.
  logic             out_valid_q;
  logic [HueW-1:0]  hue_d, hue_q, hue_base;
  logic [ChanW-1:0] sat_d, sat_q, val_q;

  // The whole pipeline moves unless a finished result is waiting.
  assign advance      = !out_valid_q || pix_out.ready;
  assign pix_in.ready = advance;

  // Pick the maximum channel; blue wins ties over green, green over red.
  always_comb begin
    blue_max  = (pix_in.blue >= pix_in.red) && (pix_in.blue >= pix_in.green);
    green_max = !blue_max && (pix_in.green >= pix_in.red);
    if (blue_max) begin
      s1_mx_d = pix_in.blue;
      s1_p_d = pix_in.red;
      s1_q_d = pix_in.green;
      s1_sector_d = SecBlue;
    end else if (green_max) begin
      s1_mx_d = pix_in.green;
      s1_p_d = pix_in.blue;
      s1_q_d = pix_in.red;
      s1_sector_d = SecGreen;
    end else begin
      s1_mx_d = pix_in.red;
      s1_p_d = pix_in.green;
      s1_q_d = pix_in.blue;
      s1_sector_d = SecRed;
    end
    if (pix_in.red <= pix_in.green) begin
      s1_mn_d = (pix_in.red <= pix_in.blue) ? pix_in.red : pix_in.blue;
    end else begin
      s1_mn_d = (pix_in.green <= pix_in.blue) ? pix_in.green : pix_in.blue;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (advance) begin
      s1_valid_q <= pix_in.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s1_mx_q     <= s1_mx_d;
      s1_mn_q     <= s1_mn_d;
      s1_p_q      <= s1_p_d;
      s1_q_q      <= s1_q_d;
      s1_sector_q <= s1_sector_d;
    end
  end

  // Stage 2: delta, numerator sign and magnitude, and both dividends.
  // 3840 * n is formed as (n << 12) - (n << 8), 255 * delta as (delta << 8) - delta.
  always_comb begin
    delta = s1_mx_q - s1_mn_q;
    neg   = s1_p_q < s1_q_q;
    nabs  = neg ? (s1_q_q - s1_p_q) : (s1_p_q - s1_q_q);
    st_d[0].hrem   = (HueRemW'(nabs) << 12) - (HueRemW'(nabs) << 8);
    st_d[0].hdiv   = delta;
    st_d[0].hq     = '0;
    st_d[0].srem   = (SatRemW'(delta) << 8) - SatRemW'(delta);
    st_d[0].sdiv   = s1_mx_q;
    st_d[0].sq     = '0;
    st_d[0].sector = (s1_sector_q == SecRed && neg) ? SecRedWrap : s1_sector_q;
    st_d[0].neg    = neg;
    st_d[0].gray   = (delta == '0);
    st_d[0].black  = (s1_mx_q == '0);
    st_d[0].value  = s1_mx_q;
  end

  // Restoring division, one quotient bit per stage, most significant first.
  for (genvar k = 0; k < DivSteps; k++) begin : g_div
    localparam int unsigned Bit = DivSteps - 1 - k;
    logic [HueRemW-1:0] hsub;
    logic [SatRemW-1:0] ssub;
    logic               hge, sge;

    always_comb begin
      st_d[k+1] = st_q[k];
      hsub = HueRemW'(st_q[k].hdiv) << Bit;
      hge  = st_q[k].hrem >= hsub;
      if (hge) begin
        st_d[k+1].hrem = st_q[k].hrem - hsub;
      end
      st_d[k+1].hq[Bit] = hge;
      ssub = SatRemW'(st_q[k].sdiv) << (Bit % SatQW);
      sge  = (k >= SatStart) && (st_q[k].srem >= ssub);
      if (sge) begin
        st_d[k+1].srem = st_q[k].srem - ssub;
      end
      if (k >= SatStart) begin
        st_d[k+1].sq[Bit % SatQW] = sge;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_valid_q <= '0;
    end else if (advance) begin
      st_valid_q <= {st_valid_q[DivSteps-1:0], s1_valid_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      for (int i = 0; i <= DivSteps; i++) begin
        st_q[i] <= st_d[i];
      end
    end
  end

  // Output stage: sector base plus or minus the hue quotient, or zero hue for a gray pixel.
  always_comb begin
    hue_base = HueW'(st_q[DivSteps].sector) * HueSector;
    if (st_q[DivSteps].gray) begin
      hue_d = '0;
    end else if (st_q[DivSteps].neg) begin
      hue_d = hue_base - HueW'(st_q[DivSteps].hq);
    end else begin
      hue_d = hue_base + HueW'(st_q[DivSteps].hq);
    end
    sat_d = st_q[DivSteps].black ? '0 : st_q[DivSteps].sq;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= st_valid_q[DivSteps];
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      hue_q <= hue_d;
      sat_q <= sat_d;
      val_q <= st_q[DivSteps].value;
    end
  end

  assign pix_out.valid      = out_valid_q;
  assign pix_out.hue        = hue_q;
  assign pix_out.saturation = sat_q;
  assign pix_out.value      = val_q;

  // A transfer always lands in stage 1.
  `ASSERT_NEXT(a_in_to_s1, pix_in.valid && pix_in.ready, s1_valid_q)
  // Zero saturation means a gray pixel, whose hue is zero.
  `ASSERT_SAME(a_gray_hue, out_valid_q && sat_q == '0, hue_q == '0)
  // Hue stays below 360 degrees.
  `ASSERT_SAME(a_hue_range, out_valid_q, hue_q < 15'd23040)
  // The final hue remainder is below the divisor.
  `ASSERT_SAME(a_hue_rem, st_valid_q[DivSteps] && !st_q[DivSteps].gray,
               st_q[DivSteps].hrem < HueRemW'(st_q[DivSteps].hdiv))
  // The final saturation remainder is below the divisor.
  `ASSERT_SAME(a_sat_rem, st_valid_q[DivSteps] && !st_q[DivSteps].black,
               st_q[DivSteps].srem < SatRemW'(st_q[DivSteps].sdiv))

endmodule
